/* rtl/csgv_pkg.sv */
package csgv_pkg;

  // field and register widths
  localparam int GRID_W  = 8;
  localparam int RES_W   = 8;
  localparam int COMP_W  = 20;
  localparam int VEC_W   = 3 * COMP_W;
  localparam int RAD_W   = 20;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;

  // normal datapath widths
  localparam int PROD_W  = COMP_W + RES_W + 1;
  localparam int NSUM_W  = PROD_W + 2;
  localparam int MAG_W   = 29;
  localparam int NMAG_W  = 30;
  localparam int SH_W    = 5;
  localparam int SQ_W    = 2 * NMAG_W;
  localparam int SUM_W   = 62;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 1;
  localparam int QUO_W   = 15;
  localparam int NUM_W   = NMAG_W + QUO_W + 1;
  localparam int DEN_W   = ROOT_W + 1;
  localparam int NRM_W   = 16;
  localparam int NRM_FRAC = 14;
  localparam int PM_W    = QUO_W + RAD_W;
  localparam int PR_W    = PM_W - NRM_FRAC;
  localparam int P2_W    = PR_W + 1;
  localparam int POS_W   = 24;
  localparam int PSUM_W  = POS_W + 1;
  localparam int POS_MAX = 8388607;
  localparam int POS_MIN = -8388608;
  localparam int ROUND_HALF = 1 << (NRM_FRAC - 1);

  // texcoord and index widths
  localparam int TQ_W    = 16;
  localparam int TEX_W   = TQ_W + 1;
  localparam int TNUM_W  = GRID_W + TQ_W + 1;
  localparam int TDEN_W  = RES_W + 1;
  localparam int IDX_W   = 16;
  localparam int IPROD_W = GRID_W + RES_W + 1;
  localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(1 << TQ_W);

  // pipeline latencies in register stages
  localparam int FRONT_LAT = 6;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int NDIV_LAT  = QUO_W + 1;
  localparam int POST_LAT  = 3;
  localparam int DEPTH     = FRONT_LAT + SQRT_LAT + NDIV_LAT + POST_LAT;
  localparam int SIDE_LAT  = TQ_W + 1;
  localparam int SIDE_DLY  = DEPTH - 1 - SIDE_LAT;
  localparam int SGN_DLY   = SQRT_LAT + NDIV_LAT;

  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 176;

  typedef logic [2:0][NMAG_W-1:0] mag_vec_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } sgn_t;

  typedef struct packed {
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [IDX_W-1:0] vertex_index;
    logic             has_quad;
  } side_t;

  typedef enum logic [2:0] {
    REG_CORNER = 3'd0,
    REG_U_AXIS = 3'd1,
    REG_V_AXIS = 3'd2,
    REG_ORIGIN = 3'd3,
    REG_RADIUS = 3'd4,
    REG_RES    = 3'd5
  } reg_idx_t;

endpackage

/* rtl/cube_sphere_grid_vertex.sv */
// channel   dir  handshake                   payload
// s_*       in   s_tvalid / s_tready         s_tdata: grid_x, grid_y
// m_*       out  m_tvalid / m_tready         m_tdata: pos, norm, tex, index; m_tuser: has_quad
// apb       in   psel, penable, pwrite       paddr, pwdata, prdata (8-byte registers)
//
// one word in per cycle and one word out per cycle while the output is not stalled; the
// pipeline holds the 31-stage square root and the 16-stage rounding divider in series
// rst clears the valid bits and loads the register reset values
// a stalled output freezes every stage at once; s_tready falls with it

module cube_sphere_grid_vertex import csgv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // grid point in: grid_x [7:0], grid_y [15:8]
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,
  // vertex out: pos_x [23:0], pos_y [47:24], pos_z [71:48], norm_x [87:72],
  // norm_y [103:88], norm_z [119:104], tex_u [136:120], tex_v [153:137],
  // vertex_index [169:154], zero fill [175:170]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_OUT_W-1:0] m_tdata,
  // has_quad [0]
  output logic [0:0]             m_tuser,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [VEC_W-1:0] face_corner;
  logic [VEC_W-1:0] u_axis;
  logic [VEC_W-1:0] v_axis;
  logic [VEC_W-1:0] sphere_origin;
  logic [RAD_W-1:0] sphere_radius;
  logic [RES_W-1:0] grid_resolution;

  logic             wr;
  reg_idx_t         ridx;
  logic [RES_W-1:0] res;
  logic             en;
  logic [DEPTH-1:0] vld;

  logic [SUM_W-1:0]  f_sum;
  mag_vec_t          f_mag;
  sgn_t              f_sgn;
  logic [ROOT_W-1:0] len;
  mag_vec_t          mag_dly [SQRT_LAT];
  sgn_t              sgn_dly [SGN_DLY];
  logic [QUO_W-1:0]  quo [3];
  side_t             s_side;
  side_t             side_dly [SIDE_DLY];

  logic signed [NRM_W-1:0] nrm1 [3];
  logic [PM_W-1:0]         pm1  [3];
  logic                    neg1 [3];
  logic signed [NRM_W-1:0] nrm2 [3];
  logic signed [P2_W-1:0]  p2   [3];
  logic signed [NRM_W-1:0] nrm_o [3];
  logic [POS_W-1:0]        pos_o [3];
  side_t                   side_o;

  // configuration registers
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign ridx   = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      face_corner     <= '0;
      u_axis          <= '0;
      v_axis          <= '0;
      sphere_origin   <= '0;
      sphere_radius   <= RAD_W'(4096);
      grid_resolution <= RES_W'(16);
    end else if (wr) begin
      unique case (ridx)
        REG_CORNER: face_corner     <= pwdata[VEC_W-1:0];
        REG_U_AXIS: u_axis          <= pwdata[VEC_W-1:0];
        REG_V_AXIS: v_axis          <= pwdata[VEC_W-1:0];
        REG_ORIGIN: sphere_origin   <= pwdata[VEC_W-1:0];
        REG_RADIUS: sphere_radius   <= pwdata[RAD_W-1:0];
        REG_RES:    grid_resolution <= pwdata[RES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_CORNER: prdata = DATA_W'(face_corner);
      REG_U_AXIS: prdata = DATA_W'(u_axis);
      REG_V_AXIS: prdata = DATA_W'(v_axis);
      REG_ORIGIN: prdata = DATA_W'(sphere_origin);
      REG_RADIUS: prdata = DATA_W'(sphere_radius);
      REG_RES:    prdata = DATA_W'(grid_resolution);
      default:    prdata = '0;
    endcase
  end

  // resolution zero acts as one
  assign res = (grid_resolution == '0) ? RES_W'(1) : grid_resolution;

  // global advance: everything moves unless the output word is held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // face vector, normalization, sum of squares
  csgv_front u_front (
    .clk    (clk),
    .en     (en),
    .grid_x (s_tdata[GRID_W-1:0]),
    .grid_y (s_tdata[2*GRID_W-1:GRID_W]),
    .res    (res),
    .corner (face_corner),
    .u_ax   (u_axis),
    .v_ax   (v_axis),
    .sum    (f_sum),
    .mag    (f_mag),
    .sgn    (f_sgn)
  );

  csgv_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (f_sum),
    .root     (len)
  );

  // magnitudes wait for the root, signs wait for the quotients
  always_ff @(posedge clk) begin
    if (en) begin
      mag_dly[0] <= f_mag;
      for (int k = 1; k < SQRT_LAT; k++) mag_dly[k] <= mag_dly[k-1];
      sgn_dly[0] <= f_sgn;
      for (int k = 1; k < SGN_DLY; k++) sgn_dly[k] <= sgn_dly[k-1];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    csgv_ndiv u_ndiv (
      .clk (clk),
      .en  (en),
      .mag (mag_dly[SQRT_LAT-1][c]),
      .len (len),
      .quo (quo[c])
    );
  end

  // texcoords, vertex index and quad flag
  csgv_side u_side (
    .clk    (clk),
    .en     (en),
    .grid_x (s_tdata[GRID_W-1:0]),
    .grid_y (s_tdata[2*GRID_W-1:GRID_W]),
    .res    (res),
    .side   (s_side)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_dly[0] <= s_side;
      for (int k = 1; k < SIDE_DLY; k++) side_dly[k] <= side_dly[k-1];
    end
  end

  // post stage 1: signed normal and radius product
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        if (sgn_dly[SGN_DLY-1].zero) begin
          nrm1[c] <= '0;
          pm1[c]  <= '0;
          neg1[c] <= 1'b0;
        end else begin
          nrm1[c] <= sgn_dly[SGN_DLY-1].neg[c] ? -NRM_W'(quo[c]) : NRM_W'(quo[c]);
          pm1[c]  <= PM_W'(quo[c]) * PM_W'(sphere_radius);
          neg1[c] <= sgn_dly[SGN_DLY-1].neg[c];
        end
      end
    end
  end

  // post stage 2: round half away from zero and apply the sign
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        logic [PM_W-1:0] rnd;
        rnd = pm1[c] + PM_W'(ROUND_HALF);
        p2[c]   <= neg1[c] ? -P2_W'(rnd[PM_W-1:NRM_FRAC]) : P2_W'(rnd[PM_W-1:NRM_FRAC]);
        nrm2[c] <= nrm1[c];
      end
    end
  end

  // output register: add origin and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        logic signed [PSUM_W-1:0] ps;
        ps = PSUM_W'(p2[c]) + PSUM_W'($signed(sphere_origin[COMP_W*c +: COMP_W]));
        if (ps > PSUM_W'(POS_MAX)) begin
          pos_o[c] <= POS_W'(POS_MAX);
        end else if (ps < PSUM_W'(POS_MIN)) begin
          pos_o[c] <= POS_W'(POS_MIN);
        end else begin
          pos_o[c] <= ps[POS_W-1:0];
        end
        nrm_o[c] <= nrm2[c];
      end
      side_o <= side_dly[SIDE_DLY-1];
    end
  end

  assign m_tdata = {6'b0, side_o.vertex_index, side_o.tex_v, side_o.tex_u,
                    nrm_o[2], nrm_o[1], nrm_o[0], pos_o[2], pos_o[1], pos_o[0]};
  assign m_tuser = side_o.has_quad;

endmodule

/* rtl/csgv_front.sv */
module csgv_front import csgv_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [GRID_W-1:0] grid_x,
  input  logic [GRID_W-1:0] grid_y,
  input  logic [RES_W-1:0]  res,
  input  logic [VEC_W-1:0]  corner,
  input  logic [VEC_W-1:0]  u_ax,
  input  logic [VEC_W-1:0]  v_ax,
  output logic [SUM_W-1:0]  sum,
  output mag_vec_t          mag,
  output sgn_t              sgn
);

  logic signed [PROD_W-1:0] pc [3];
  logic signed [PROD_W-1:0] pu [3];
  logic signed [PROD_W-1:0] pv [3];
  logic [2:0][MAG_W-1:0]    mag2;
  logic [2:0]               neg2;
  logic [2:0][MAG_W-1:0]    mag3;
  logic [SH_W-1:0]          sh3;
  sgn_t                     sgn3;
  mag_vec_t                 mag4;
  sgn_t                     sgn4;
  logic [SQ_W-1:0]          sq5 [3];
  mag_vec_t                 mag5;
  sgn_t                     sgn5;

  logic [2:0][MAG_W-1:0]    mag2_next;
  logic [2:0]               neg2_next;
  logic [SH_W-1:0]          sh3_next;
  logic                     zero3_next;

  // stage 1: the nine component products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pc[c] <= $signed(corner[COMP_W*c +: COMP_W]) * $signed({1'b0, res});
        pu[c] <= $signed({1'b0, grid_x}) * $signed(u_ax[COMP_W*c +: COMP_W]);
        pv[c] <= $signed({1'b0, grid_y}) * $signed(v_ax[COMP_W*c +: COMP_W]);
      end
    end
  end

  // stage 2: sum and split into sign and magnitude
  always_comb begin
    logic signed [NSUM_W-1:0] n;
    for (int c = 0; c < 3; c++) begin
      n = NSUM_W'(pc[c]) + NSUM_W'(pu[c]) + NSUM_W'(pv[c]);
      neg2_next[c] = n[NSUM_W-1];
      mag2_next[c] = n[NSUM_W-1] ? MAG_W'(-n) : MAG_W'(n);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2 <= mag2_next;
      neg2 <= neg2_next;
    end
  end

  // stage 3: leading one of the largest magnitude gives the shift
  always_comb begin
    logic [MAG_W-1:0] orv;
    logic [SH_W-1:0]  msb;
    orv = mag2[0] | mag2[1] | mag2[2];
    msb = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) msb = SH_W'(i);
    end
    sh3_next = SH_W'(NMAG_W - 1 - int'(msb));
    zero3_next = (orv == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag3      <= mag2;
      sh3       <= sh3_next;
      sgn3.neg  <= neg2;
      sgn3.zero <= zero3_next;
    end
  end

  // stage 4: normalize so the largest magnitude has bit 29 set
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        mag4[c] <= NMAG_W'({1'b0, mag3[c]} << sh3);
      end
      sgn4 <= sgn3;
    end
  end

  // stage 5: squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq5[c] <= SQ_W'(mag4[c]) * SQ_W'(mag4[c]);
      end
      mag5 <= mag4;
      sgn5 <= sgn4;
    end
  end

  // stage 6: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SUM_W'(sq5[0]) + SUM_W'(sq5[1]) + SUM_W'(sq5[2]);
      mag <= mag5;
      sgn <= sgn5;
    end
  end

endmodule

/* rtl/csgv_sqrt.sv */
module csgv_sqrt import csgv_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SUM_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root
);

  logic [SUM_W-1:0]  rad_s  [ROOT_W];
  logic [REM_W-1:0]  rem_s  [ROOT_W];
  logic [ROOT_W-1:0] root_s [ROOT_W];

  // one root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [SUM_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  ext;
    logic [REM_W+1:0]  trial;

    if (k == 0) begin : g_first
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_s[k-1];
      assign rem_in  = rem_s[k-1];
      assign root_in = root_s[k-1];
    end

    assign ext   = {rem_in, rad_in[SUM_W-1-2*k -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[k] <= rad_in;
        if (ext >= trial) begin
          rem_s[k]  <= REM_W'(ext - trial);
          root_s[k] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_s[k]  <= ext[REM_W-1:0];
          root_s[k] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_s[ROOT_W-1];

endmodule

/* rtl/csgv_ndiv.sv */
module csgv_ndiv import csgv_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [NMAG_W-1:0] mag,
  input  logic [ROOT_W-1:0] len,
  output logic [QUO_W-1:0]  quo
);

  logic [NUM_W-1:0] rem_s [NDIV_LAT];
  logic [DEN_W-1:0] den_s [NDIV_LAT];
  logic [QUO_W-1:0] quo_s [NDIV_LAT];

  // rounded quotient: (2*mag*2^14 + len) / (2*len)
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= NUM_W'({mag, {(QUO_W){1'b0}}}) + NUM_W'(len);
      den_s[0] <= {len, 1'b0};
      quo_s[0] <= '0;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 1; k < NDIV_LAT; k++) begin : g_step
    logic [NUM_W-1:0] trial;
    assign trial = NUM_W'(den_s[k-1]) << (QUO_W - k);

    always_ff @(posedge clk) begin
      if (en) begin
        den_s[k] <= den_s[k-1];
        if (rem_s[k-1] >= trial) begin
          rem_s[k] <= rem_s[k-1] - trial;
          quo_s[k] <= {quo_s[k-1][QUO_W-2:0], 1'b1};
        end else begin
          rem_s[k] <= rem_s[k-1];
          quo_s[k] <= {quo_s[k-1][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_s[NDIV_LAT-1];

endmodule

/* rtl/csgv_side.sv */
module csgv_side import csgv_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [GRID_W-1:0] grid_x,
  input  logic [GRID_W-1:0] grid_y,
  input  logic [RES_W-1:0]  res,
  output side_t             side
);

  logic [TNUM_W-1:0] rem_u [SIDE_LAT];
  logic [TNUM_W-1:0] rem_v [SIDE_LAT];
  logic [TQ_W-1:0]   quo_u [SIDE_LAT];
  logic [TQ_W-1:0]   quo_v [SIDE_LAT];
  logic              sat_u [SIDE_LAT];
  logic              sat_v [SIDE_LAT];
  logic [IDX_W-1:0]  index [SIDE_LAT];
  logic              quad  [SIDE_LAT];

  logic [TDEN_W-1:0]  den;
  logic [IPROD_W-1:0] vprod;

  assign den   = {res, 1'b0};
  assign vprod = IPROD_W'(grid_y) * (IPROD_W'(res) + IPROD_W'(1)) + IPROD_W'(grid_x);

  // setup: rounded dividend, saturation at or past the patch edge, index, quad
  always_ff @(posedge clk) begin
    if (en) begin
      rem_u[0] <= {grid_x, {(TQ_W+1){1'b0}}} + TNUM_W'(res);
      rem_v[0] <= {grid_y, {(TQ_W+1){1'b0}}} + TNUM_W'(res);
      quo_u[0] <= '0;
      quo_v[0] <= '0;
      sat_u[0] <= (grid_x >= res);
      sat_v[0] <= (grid_y >= res);
      index[0] <= vprod[IDX_W-1:0];
      quad[0]  <= (grid_x < res) && (grid_y < res);
    end
  end

  // one texcoord bit per stage for u and v
  for (genvar k = 1; k < SIDE_LAT; k++) begin : g_step
    logic [TNUM_W-1:0] trial;
    assign trial = TNUM_W'(den) << (TQ_W - k);

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_u[k-1] >= trial) begin
          rem_u[k] <= rem_u[k-1] - trial;
          quo_u[k] <= {quo_u[k-1][TQ_W-2:0], 1'b1};
        end else begin
          rem_u[k] <= rem_u[k-1];
          quo_u[k] <= {quo_u[k-1][TQ_W-2:0], 1'b0};
        end
        if (rem_v[k-1] >= trial) begin
          rem_v[k] <= rem_v[k-1] - trial;
          quo_v[k] <= {quo_v[k-1][TQ_W-2:0], 1'b1};
        end else begin
          rem_v[k] <= rem_v[k-1];
          quo_v[k] <= {quo_v[k-1][TQ_W-2:0], 1'b0};
        end
        sat_u[k] <= sat_u[k-1];
        sat_v[k] <= sat_v[k-1];
        index[k] <= index[k-1];
        quad[k]  <= quad[k-1];
      end
    end
  end

  assign side.tex_u = sat_u[SIDE_LAT-1] ? TEX_ONE : {1'b0, quo_u[SIDE_LAT-1]};
  assign side.tex_v = sat_v[SIDE_LAT-1] ? TEX_ONE : {1'b0, quo_v[SIDE_LAT-1]};
  assign side.vertex_index = index[SIDE_LAT-1];
  assign side.has_quad     = quad[SIDE_LAT-1];

endmodule

/* sim/cube_sphere_grid_vertex_test.sv */
`timescale 1ns / 100ps

module cube_sphere_grid_vertex_test;
  import csgv_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  vertex_index;
    logic [TEX_W-1:0]  tex_v;
    logic [TEX_W-1:0]  tex_u;
    logic [NRM_W-1:0]  norm_z;
    logic [NRM_W-1:0]  norm_y;
    logic [NRM_W-1:0]  norm_x;
    logic [POS_W-1:0]  pos_z;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_x;
    logic              has_quad;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [TDATA_IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // shadow copy of the register file
  logic [VEC_W-1:0] corner_q, u_axis_q, v_axis_q, origin_q;
  logic [RAD_W-1:0] radius_q;
  logic [RES_W-1:0] res_q;

  vertex_t expected_vertices[$];
  int errors = 0;
  bit stall_enable = 1'b1;

  cube_sphere_grid_vertex dut (.*);

  always #5 clk = ~clk;

  // gap length, mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic longint comp(logic [VEC_W-1:0] v, int c);
    logic signed [COMP_W-1:0] f;
    f = v[COMP_W*c +: COMP_W];
    return longint'(f);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // expected vertex for one grid point under the current registers
  function automatic vertex_t sphere_vertex(logic [7:0] gx, logic [7:0] gy);
    vertex_t o;
    longint unsigned res, mag[3], m, s, len, q, pm, t;
    longint n, p, nrm[3];
    bit neg[3];
    res = res_q;
    if (res < 1) res = 1;
    if (res > 255) res = 255;
    m = 0;
    s = 0;
    for (int c = 0; c < 3; c++) begin
      n = comp(corner_q, c) * longint'(res) + longint'(gx) * comp(u_axis_q, c)
          + longint'(gy) * comp(v_axis_q, c);
      neg[c] = n < 0;
      mag[c] = neg[c] ? -n : n;
      if (mag[c] > m) m = mag[c];
    end
    if (m == 0) begin
      for (int c = 0; c < 3; c++) nrm[c] = 0;
    end else begin
      while (m < (64'd1 << 29)) begin
        m <<= 1;
        for (int c = 0; c < 3; c++) mag[c] <<= 1;
      end
      for (int c = 0; c < 3; c++) s += mag[c] * mag[c];
      len = int_sqrt(s);
      for (int c = 0; c < 3; c++) begin
        q = ((mag[c] << 14) * 2 + len) / (len * 2);
        nrm[c] = neg[c] ? -longint'(q) : longint'(q);
      end
    end
    for (int c = 0; c < 3; c++) begin
      pm = (nrm[c] < 0 ? -nrm[c] : nrm[c]) * longint'(radius_q);
      p = longint'((pm + (64'd1 << 13)) >> 14);
      if (nrm[c] < 0) p = -p;
      p += comp(origin_q, c);
      if (p > POS_MAX) p = POS_MAX;
      if (p < POS_MIN) p = POS_MIN;
      case (c)
        0: begin o.pos_x = p[23:0]; o.norm_x = nrm[c][15:0]; end
        1: begin o.pos_y = p[23:0]; o.norm_y = nrm[c][15:0]; end
        default: begin o.pos_z = p[23:0]; o.norm_z = nrm[c][15:0]; end
      endcase
    end
    t = ((longint'(gx) << 16) * 2 + res) / (res * 2);
    o.tex_u = t > 65536 ? TEX_ONE : t[TEX_W-1:0];
    t = ((longint'(gy) << 16) * 2 + res) / (res * 2);
    o.tex_v = t > 65536 ? TEX_ONE : t[TEX_W-1:0];
    t = longint'(gy) * (res + 1) + gx;
    o.vertex_index = t[15:0];
    o.has_quad = (gx < res) && (gy < res);
    return o;
  endfunction

  // one register write, setup then access
  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(8 * idx);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CORNER: corner_q = val[VEC_W-1:0];
      REG_U_AXIS: u_axis_q = val[VEC_W-1:0];
      REG_V_AXIS: v_axis_q = val[VEC_W-1:0];
      REG_ORIGIN: origin_q = val[VEC_W-1:0];
      REG_RADIUS: radius_q = val[RAD_W-1:0];
      default:    res_q = val[RES_W-1:0];
    endcase
  endtask

  // send one grid point, predicting its vertex
  task automatic send_point(logic [7:0] gx, logic [7:0] gy, bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {gy, gx};
    expected_vertices.push_back(sphere_vertex(gx, gy));
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(negedge clk);
    repeat (DEPTH + 10) @(negedge clk);
  endtask

  function automatic logic [VEC_W-1:0] rand_vec(int lim);
    logic [VEC_W-1:0] v;
    for (int c = 0; c < 3; c++)
      v[COMP_W*c +: COMP_W] = COMP_W'($urandom_range(0, 2 * lim) - lim);
    return v;
  endfunction

  // points at patch corners, edges, beyond the patch and the extremes
  task automatic test_directed();
    write_reg(REG_CORNER, {20'hFF000, 20'h01000, 20'hFF000});
    write_reg(REG_U_AXIS, {20'h00000, 20'h00000, 20'h02000});
    write_reg(REG_V_AXIS, {20'h02000, 20'h00000, 20'h00000});
    write_reg(REG_ORIGIN, {20'h00800, 20'hFF800, 20'h00100});
    write_reg(REG_RADIUS, 64'd4096);
    write_reg(REG_RES, 64'd16);
    send_point(0, 0, 0);
    send_point(16, 0, 0);
    send_point(0, 16, 0);
    send_point(16, 16, 0);
    send_point(8, 8, 0);
    send_point(15, 15, 0);
    send_point(17, 3, 0);
    send_point(255, 255, 0);
    send_point(8'hAA, 8'h55, 0);
    send_point(8'h55, 8'hAA, 0);
    drain();
    // zero-length point at the patch center, huge radius and saturation
    write_reg(REG_CORNER, {20'hFF000, 20'hFF000, 20'hFF000});
    write_reg(REG_U_AXIS, {20'h00000, 20'h00000, 20'h02000});
    write_reg(REG_V_AXIS, {20'h02000, 20'h02000, 20'h00000});
    write_reg(REG_ORIGIN, {20'h7FFFF, 20'h80000, 20'h7FFFF});
    write_reg(REG_RADIUS, 64'hFFFFF);
    send_point(8, 8, 0);
    send_point(0, 0, 0);
    send_point(16, 16, 0);
    send_point(16, 0, 0);
    drain();
    // resolution zero clamps to one, resolution maximum, largest vertex index
    write_reg(REG_RADIUS, 64'd0);
    write_reg(REG_ORIGIN, 64'd0);
    write_reg(REG_RES, 64'd0);
    send_point(0, 1, 0);
    send_point(2, 2, 0);
    drain();
    write_reg(REG_RES, 64'd255);
    send_point(254, 254, 0);
    send_point(255, 255, 0);
    drain();
    write_reg(REG_CORNER, {20'h7FFFF, 20'h80000, 20'h7FFFF});
    write_reg(REG_U_AXIS, {20'h80000, 20'h7FFFF, 20'h80000});
    write_reg(REG_V_AXIS, {20'h7FFFF, 20'h7FFFF, 20'h80000});
    write_reg(REG_RADIUS, 64'd12345);
    send_point(0, 0, 0);
    send_point(255, 0, 0);
    send_point(0, 255, 0);
    drain();
  endtask

  // random geometry phases, mostly in-range points
  task automatic test_random();
    int gx, gy, r, lim;
    for (int ph = 0; ph < 8; ph++) begin
      lim = (ph % 2) ? 524287 : 8192;
      write_reg(REG_CORNER, rand_vec(lim));
      write_reg(REG_U_AXIS, rand_vec(lim));
      write_reg(REG_V_AXIS, rand_vec(lim));
      write_reg(REG_ORIGIN, rand_vec(ph == 7 ? 524287 : 40000));
      write_reg(REG_RADIUS, 64'($urandom_range(0, 1048575)));
      r = (ph < 5) ? $urandom_range(1, 32) : $urandom_range(0, 255);
      if (ph == 6) r = 255;
      write_reg(REG_RES, 64'(r));
      if (r == 0) r = 1;
      for (int i = 0; i < 160; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          gx = $urandom_range(0, 255);
          gy = $urandom_range(0, 255);
        end else begin
          gx = $urandom_range(0, r);
          gy = $urandom_range(0, r);
        end
        send_point(8'(gx), 8'(gy), (i / 40) % 4 != 3);
      end
      drain();
    end
  endtask

  // sink side back-pressure
  always @(negedge clk) begin
    int g;
    if (rst || !stall_enable) m_tready <= 1'b1;
    else begin
      g = pick_gap();
      m_tready <= (g == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  // compare each accepted vertex against the oldest prediction
  always @(posedge clk) begin
    vertex_t got, exp_v;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[169:0], m_tuser[0]};
      if (expected_vertices.size() == 0) begin
        $display("%0t: unexpected vertex %h", $time, got);
        errors++;
      end else begin
        exp_v = expected_vertices.pop_front();
        if (got !== exp_v) begin
          $display("%0t: vertex mismatch expected %h actual %h", $time, exp_v, got);
          errors++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("FAIL cube_sphere_grid_vertex");
    $finish;
  end

  initial begin
    corner_q = '0;
    u_axis_q = '0;
    v_axis_q = '0;
    origin_q = '0;
    radius_q = 20'd4096;
    res_q = 8'd16;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    // reset values: zero-length point everywhere
    send_point(3, 4, 0);
    drain();
    test_directed();
    test_random();
    if (errors == 0) $display("PASS cube_sphere_grid_vertex");
    else $display("FAIL cube_sphere_grid_vertex");
    $finish;
  end

endmodule
